// ===== rtl/vfst_pkg.sv =====
`timescale 1ns / 1ps

package vfst_pkg;

   // fingering codes as the valve combinations are usually written
   localparam logic [6:0] FING_NONE = 7'd0;
   localparam logic [6:0] FING_1    = 7'd1;
   localparam logic [6:0] FING_2    = 7'd2;
   localparam logic [6:0] FING_3    = 7'd3;
   localparam logic [6:0] FING_12   = 7'd12;
   localparam logic [6:0] FING_13   = 7'd13;
   localparam logic [6:0] FING_23   = 7'd23;
   localparam logic [6:0] FING_123  = 7'd123;

   localparam int CHART_LEN  = 31;
   localparam int NOTE_COUNT = 31;
   localparam int SEARCH_LEN = (NOTE_COUNT < CHART_LEN) ? NOTE_COUNT : CHART_LEN;

   localparam longint unsigned SAMPLE_RATE_HZ = 64'd44100;

   localparam logic [7:0] SILENT_SAMPLE = 8'd128;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [6:0] CHART_CODE [CHART_LEN] = '{
      FING_NONE, FING_23, FING_13, FING_12, FING_1, FING_2, FING_NONE,
      FING_NONE, FING_23, FING_13, FING_12, FING_1, FING_2, FING_NONE,
      FING_23, FING_13, FING_12, FING_1, FING_2,
      FING_NONE, FING_13, FING_12, FING_1,
      FING_NONE, FING_2, FING_NONE,
      FING_23, FING_13, FING_12, FING_1, FING_2
   };

   localparam logic [2:0] CHART_OCTAVE [CHART_LEN] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5
   };

   // tenths of a hertz
   localparam logic [13:0] CHART_FREQ [CHART_LEN] = '{
      14'd1850, 14'd1960, 14'd2077, 14'd2200, 14'd2331, 14'd2469, 14'd2616,
      14'd2772, 14'd2937, 14'd3111, 14'd3296, 14'd3492, 14'd3700, 14'd3920,
      14'd4153, 14'd4400, 14'd4662, 14'd4939, 14'd5233,
      14'd5544, 14'd5873, 14'd6223, 14'd6593,
      14'd6985, 14'd7400, 14'd7840,
      14'd8306, 14'd8800, 14'd9323, 14'd9878, 14'd10470
   };

   typedef struct packed {
      logic       found;
      logic [4:0] index;
   } note_match_type;

   // one rom entry, evaluated at elaboration; taylor series to x^15 in q30
   function automatic logic [7:0] sine_entry(input int unsigned k,
                                             input int unsigned addr_bits);
      longint unsigned qsh;
      longint unsigned q;
      longint unsigned quad;
      longint unsigned j;
      longint unsigned jj;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned mag;
      longint unsigned num;
      qsh  = 64'(addr_bits) - 64'd2;
      q    = 64'd1 << qsh;
      quad = 64'(k) >> qsh;
      j    = 64'(k) & (q - 64'd1);
      jj   = ((quad & 64'd1) != 64'd0) ? (q - j) : j;
      x    = (jj * HALF_PI_Q30) >> qsh;
      x2   = (x * x) >> 30;
      t    = Q30_ONE;
      t    = Q30_ONE - ((x2 * t) >> 30) / 210;
      t    = Q30_ONE - ((x2 * t) >> 30) / 156;
      t    = Q30_ONE - ((x2 * t) >> 30) / 110;
      t    = Q30_ONE - ((x2 * t) >> 30) / 72;
      t    = Q30_ONE - ((x2 * t) >> 30) / 42;
      t    = Q30_ONE - ((x2 * t) >> 30) / 20;
      t    = Q30_ONE - ((x2 * t) >> 30) / 6;
      s    = (x * t) >> 30;
      mag  = (s > Q30_ONE) ? Q30_ONE : s;
      num  = (quad >= 64'd2) ? (Q30_ONE - mag) : (Q30_ONE + mag);
      return 8'((num * 64'd255) >> 31);
   endfunction

endpackage

// ===== rtl/vfst_channels.sv =====
`timescale 1ns / 1ps

interface vfst_req_if;
   logic       valid;
   logic       ready;
   logic       valve_one;
   logic       valve_two;
   logic       valve_three;
   logic [4:0] octave_buttons;
   logic       sound_enable;

   modport source (
      output valid, valve_one, valve_two, valve_three, octave_buttons, sound_enable,
      input  ready
   );
   modport sink (
      input  valid, valve_one, valve_two, valve_three, octave_buttons, sound_enable,
      output ready
   );
endinterface

interface vfst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] dac_sample;
   logic       note_found;
   logic [4:0] note_index;

   modport source (
      output valid, dac_sample, note_found, note_index,
      input  ready
   );
   modport sink (
      input  valid, dac_sample, note_found, note_index,
      output ready
   );
endinterface

// ===== rtl/valve_fingering_sine_tone_generator_top.sv =====
`timescale 1ns / 1ps

// channel  | dir | handshake   | payload
// req_chan | in  | valid/ready | valve_one, valve_two, valve_three, octave_buttons, sound_enable
// rsp_chan | out | valid/ready | dac_sample, note_found, note_index
//
// one item per clock while rsp_chan takes results; a taken item passes the rom stage and then
// the output register before its result is valid; the rom stage is the registered sine rom read
// reset clears the phase accumulator and all valid flags, nothing else is swept
// the output register and the rom stage part the two sides, so an item is still
// taken while one result waits at the output

module valve_fingering_sine_tone_generator_top #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   vfst_req_if.sink   req_chan,
   vfst_rsp_if.source rsp_chan
);

   localparam int NOTES = vfst_pkg::SEARCH_LEN;

   logic [PHASE_BITS-1:0] inc_table [NOTES];

   // round-half-up increment per chart note, fixed at elaboration
   for (genvar i = 0; i < NOTES; i++) begin : g_inc
      localparam logic [63:0] INC_WIDE =
         ((64'(vfst_pkg::CHART_FREQ[i]) << PHASE_BITS) + 64'd5 * vfst_pkg::SAMPLE_RATE_HZ)
         / (64'd10 * vfst_pkg::SAMPLE_RATE_HZ);
      assign inc_table[i] = INC_WIDE[PHASE_BITS-1:0];
   end

   vfst_pkg::note_match_type match;

   logic                      req_accept;
   logic                      play;
   logic [PHASE_BITS-1:0]     phase_ff;
   logic [PHASE_BITS-1:0]     phase_in;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic [7:0]                rom_data;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      s1_play_ff;
   logic                      s1_found_ff;
   logic [4:0]                s1_index_ff;
   logic                      s1_advance;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [7:0]                out_sample_ff;
   logic [7:0]                out_sample_in;
   logic                      out_found_ff;
   logic [4:0]                out_index_ff;

   vfst_note_lookup u_lookup (
      .valve_one      (req_chan.valve_one),
      .valve_two      (req_chan.valve_two),
      .valve_three    (req_chan.valve_three),
      .octave_buttons (req_chan.octave_buttons),
      .match          (match)
   );

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign play     = req_chan.sound_enable && match.found;
   assign phase_in = play ? (phase_ff + inc_table[match.index]) : '0;
   assign rom_addr = phase_in[PHASE_BITS-1 -: SINE_ADDR_BITS];

   vfst_sine_rom #(
      .ADDR_BITS (SINE_ADDR_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
      end
   end

   // rom stage: its data register only loads on a taken item, so it holds while stalled
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_play_ff  <= play;
         s1_found_ff <= match.found;
         s1_index_ff <= match.index;
      end
   end

   assign out_valid_in  = s1_advance || (out_valid_ff && !rsp_chan.ready);
   assign out_sample_in = s1_play_ff ? rom_data : vfst_pkg::SILENT_SAMPLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_sample_ff <= out_sample_in;
         out_found_ff  <= s1_found_ff;
         out_index_ff  <= s1_index_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.dac_sample = out_sample_ff;
   assign rsp_chan.note_found = out_found_ff;
   assign rsp_chan.note_index = out_index_ff;

`ifndef ASSERT_OFF
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("taken item did not reach the rom stage");

   a_silent_clears_phase : assert property (@(posedge clock) disable iff (reset)
      req_accept && !play |=> phase_ff == '0)
      else $error("phase not cleared on a silent item");

   a_no_note_is_silent : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |->
         out_sample_ff == vfst_pkg::SILENT_SAMPLE && out_index_ff == 5'd0)
      else $error("result without a note is not silent");

   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=>
         s1_valid_ff && $stable(s1_index_ff) && $stable(rom_data))
      else $error("rom stage changed while stalled");
`endif

endmodule

// ===== rtl/vfst_note_lookup.sv =====
`timescale 1ns / 1ps

module vfst_note_lookup (
   input  logic                     valve_one,
   input  logic                     valve_two,
   input  logic                     valve_three,
   input  logic [4:0]               octave_buttons,
   output vfst_pkg::note_match_type match
);

   logic [6:0] code;
   logic [2:0] octave;

   always_comb begin
      unique case ({valve_one, valve_two, valve_three})
         3'b000:  code = vfst_pkg::FING_NONE;
         3'b001:  code = vfst_pkg::FING_3;
         3'b010:  code = vfst_pkg::FING_2;
         3'b011:  code = vfst_pkg::FING_23;
         3'b100:  code = vfst_pkg::FING_1;
         3'b101:  code = vfst_pkg::FING_13;
         3'b110:  code = vfst_pkg::FING_12;
         3'b111:  code = vfst_pkg::FING_123;
         default: code = vfst_pkg::FING_NONE;
      endcase
   end

   // lowest pressed button wins, none pressed is octave zero
   always_comb begin
      octave = 3'd0;
      for (int i = 4; i >= 0; i--) begin
         if (octave_buttons[i]) begin
            octave = 3'(i + 1);
         end
      end
   end

   // scan from the top so the first chart match is what remains
   always_comb begin
      match.found = 1'b0;
      match.index = 5'd0;
      for (int i = vfst_pkg::SEARCH_LEN - 1; i >= 0; i--) begin
         if (vfst_pkg::CHART_CODE[i] == code && vfst_pkg::CHART_OCTAVE[i] == octave) begin
            match.found = 1'b1;
            match.index = 5'(i);
         end
      end
   end

endmodule

// ===== rtl/vfst_sine_rom.sv =====
`timescale 1ns / 1ps

module vfst_sine_rom #(
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [7:0] rom_mem [DEPTH];
   logic [7:0] rd_data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      assign rom_mem[k] = vfst_pkg::sine_entry(k, ADDR_BITS);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_valve_fingering_sine_tone_generator_top.sv =====
`timescale 1ns / 1ps

module tb_valve_fingering_sine_tone_generator_top;

   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int LUT_SIZE       = 1 << SINE_ADDR_BITS;
   localparam int RANDOM_TICKS   = 1650;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_LEN       = 120;
   localparam int DRAIN_AT       = 900;
   localparam int IDLE_LIMIT     = 2000;

   // the chart as the instrument plays it, lowest note first
   localparam logic [6:0] TONE_CODE [vfst_pkg::CHART_LEN] = '{
      vfst_pkg::FING_NONE, vfst_pkg::FING_23, vfst_pkg::FING_13, vfst_pkg::FING_12,
      vfst_pkg::FING_1, vfst_pkg::FING_2, vfst_pkg::FING_NONE,
      vfst_pkg::FING_NONE, vfst_pkg::FING_23, vfst_pkg::FING_13, vfst_pkg::FING_12,
      vfst_pkg::FING_1, vfst_pkg::FING_2, vfst_pkg::FING_NONE,
      vfst_pkg::FING_23, vfst_pkg::FING_13, vfst_pkg::FING_12, vfst_pkg::FING_1,
      vfst_pkg::FING_2,
      vfst_pkg::FING_NONE, vfst_pkg::FING_13, vfst_pkg::FING_12, vfst_pkg::FING_1,
      vfst_pkg::FING_NONE, vfst_pkg::FING_2, vfst_pkg::FING_NONE,
      vfst_pkg::FING_23, vfst_pkg::FING_13, vfst_pkg::FING_12, vfst_pkg::FING_1,
      vfst_pkg::FING_2
   };
   localparam int TONE_OCTAVE [vfst_pkg::CHART_LEN] = '{
      0, 0, 0, 0, 0, 0, 0,
      1, 1, 1, 1, 1, 1, 1,
      2, 2, 2, 2, 2,
      3, 3, 3, 3,
      4, 4, 4,
      5, 5, 5, 5, 5
   };
   // tenths of a hertz
   localparam longint unsigned TONE_DHZ [vfst_pkg::CHART_LEN] = '{
      1850, 1960, 2077, 2200, 2331, 2469, 2616,
      2772, 2937, 3111, 3296, 3492, 3700, 3920,
      4153, 4400, 4662, 4939, 5233,
      5544, 5873, 6223, 6593,
      6985, 7400, 7840,
      8306, 8800, 9323, 9878, 10470
   };

   typedef struct {
      logic [2:0] valves;   // valve one, two, three from msb down
      logic [4:0] buttons;
      logic       sound;
      bit         wait_drain;
   } tick_type;

   typedef struct {
      logic [7:0] sample;
      logic       found;
      logic [4:0] index;
   } tone_type;

   logic clock;
   logic reset;

   vfst_req_if req_chan ();
   vfst_rsp_if rsp_chan ();

   valve_fingering_sine_tone_generator_top #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   tick_type          pending_ticks [$];
   tone_type          tone_expect [$];
   tick_type          cur_tick;
   logic [7:0]        sine_lut [LUT_SIZE];
   longint unsigned   tone_step [vfst_pkg::CHART_LEN];
   logic [PHASE_BITS-1:0] tone_phase;
   bit                note_sounded [vfst_pkg::CHART_LEN];
   int                silent_ticks;
   int                req_taken;
   int                rsp_taken;
   int                mismatch_count;
   int                send_gap;
   int                stall_left;
   int                hold_left;
   bit                hold_done;
   bit                rsp_holding;
   bit                busy;
   int                idle_cycles;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // q30 quarter-wave sine, taylor series to x^15 by horner, truncating each step
   function automatic longint unsigned quarter_wave(input longint unsigned j,
                                                    input longint unsigned q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      x  = j * vfst_pkg::HALF_PI_Q30 / q;
      x2 = (x * x) >> 30;
      t  = vfst_pkg::Q30_ONE;
      for (int n = 7; n >= 1; n--) begin
         t = vfst_pkg::Q30_ONE - ((x2 * t) >> 30) / longint'((2 * n) * (2 * n + 1));
      end
      s = (x * t) >> 30;
      return (s > vfst_pkg::Q30_ONE) ? vfst_pkg::Q30_ONE : s;
   endfunction

   function automatic logic [7:0] lut_value(input int k);
      longint unsigned q;
      longint unsigned quad;
      longint unsigned j;
      longint unsigned mag;
      longint unsigned num;
      q    = LUT_SIZE / 4;
      quad = longint'(k) / q;
      j    = longint'(k) % q;
      mag  = quad[0] ? quarter_wave(q - j, q) : quarter_wave(j, q);
      num  = (quad >= 2) ? (vfst_pkg::Q30_ONE - mag) : (vfst_pkg::Q30_ONE + mag);
      return 8'((num * 255) >> 31);
   endfunction

   function automatic logic [6:0] fingering_of(input logic [2:0] valves);
      case (valves)
         3'b000:  return vfst_pkg::FING_NONE;
         3'b001:  return vfst_pkg::FING_3;
         3'b010:  return vfst_pkg::FING_2;
         3'b011:  return vfst_pkg::FING_23;
         3'b100:  return vfst_pkg::FING_1;
         3'b101:  return vfst_pkg::FING_13;
         3'b110:  return vfst_pkg::FING_12;
         default: return vfst_pkg::FING_123;
      endcase
   endfunction

   function automatic logic [2:0] valves_for(input logic [6:0] code);
      case (code)
         vfst_pkg::FING_1:   return 3'b100;
         vfst_pkg::FING_2:   return 3'b010;
         vfst_pkg::FING_3:   return 3'b001;
         vfst_pkg::FING_12:  return 3'b110;
         vfst_pkg::FING_13:  return 3'b101;
         vfst_pkg::FING_23:  return 3'b011;
         vfst_pkg::FING_123: return 3'b111;
         default:            return 3'b000;
      endcase
   endfunction

   // next tone sample; advances or clears the phase
   function automatic tone_type predict_tone(input tick_type tk);
      tone_type   r;
      logic [6:0] code;
      int         octave;
      int         hit;
      code   = fingering_of(tk.valves);
      octave = 0;
      for (int i = 4; i >= 0; i--) begin
         if (tk.buttons[i]) octave = i + 1;
      end
      hit = -1;
      for (int i = 0; i < vfst_pkg::SEARCH_LEN; i++) begin
         if (hit < 0 && TONE_CODE[i] == code && TONE_OCTAVE[i] == octave) hit = i;
      end
      r.found  = (hit >= 0);
      r.index  = (hit >= 0) ? 5'(hit) : 5'd0;
      r.sample = vfst_pkg::SILENT_SAMPLE;
      if (tk.sound && hit >= 0) begin
         tone_phase = tone_phase + PHASE_BITS'(tone_step[hit]);
         r.sample = sine_lut[tone_phase >> (PHASE_BITS - SINE_ADDR_BITS)];
         note_sounded[hit] = 1'b1;
      end else begin
         tone_phase = '0;
         silent_ticks++;
      end
      return r;
   endfunction

   task automatic push_tick(input logic [2:0] valves, input logic [4:0] buttons,
                            input logic sound);
      tick_type tk;
      tk.valves     = valves;
      tk.buttons    = buttons;
      tk.sound      = sound;
      tk.wait_drain = 1'b0;
      pending_ticks.push_back(tk);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid          <= 1'b0;
         req_chan.valve_one      <= 1'b0;
         req_chan.valve_two      <= 1'b0;
         req_chan.valve_three    <= 1'b0;
         req_chan.octave_buttons <= 5'd0;
         req_chan.sound_enable   <= 1'b0;
         send_gap   = 0;
         tone_phase = '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            tone_expect.push_back(predict_tone(cur_tick));
            req_taken++;
            send_gap = (rsp_holding || ((req_taken / 150) % 4) == 2) ? 0 : pick_gap();
            busy = 1'b0;
         end else begin
            busy = req_chan.valid;
         end
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_ticks.size() > 0 &&
                         !(pending_ticks[0].wait_drain && tone_expect.size() != 0)) begin
               cur_tick = pending_ticks.pop_front();
               req_chan.valve_one      <= cur_tick.valves[2];
               req_chan.valve_two      <= cur_tick.valves[1];
               req_chan.valve_three    <= cur_tick.valves[0];
               req_chan.octave_buttons <= cur_tick.buttons;
               req_chan.sound_enable   <= cur_tick.sound;
               req_chan.valid          <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      tone_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken++;
            if (tone_expect.size() == 0) begin
               $error("unexpected item: dac_sample %0d note_found %0d note_index %0d",
                      rsp_chan.dac_sample, rsp_chan.note_found, rsp_chan.note_index);
               mismatch_count++;
            end else begin
               want = tone_expect.pop_front();
               if (rsp_chan.dac_sample !== want.sample) begin
                  $error("dac_sample: expected %0d, got %0d", want.sample,
                         rsp_chan.dac_sample);
                  mismatch_count++;
               end
               if (rsp_chan.note_found !== want.found) begin
                  $error("note_found: expected %0d, got %0d", want.found,
                         rsp_chan.note_found);
                  mismatch_count++;
               end
               if (rsp_chan.note_index !== want.index) begin
                  $error("note_index: expected %0d, got %0d", want.index,
                         rsp_chan.note_index);
                  mismatch_count++;
               end
            end
            stall_left = (((rsp_taken / 170) % 4) == 1) ? 0 : pick_gap();
         end
         if (!hold_done && rsp_taken >= HOLD_AT) begin
            // long back-pressure so the block fills and stops taking items
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_holding = 1'b1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_holding = 1'b0;
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_holding = 1'b0;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no item moving", IDLE_LIMIT);
            $display("valve_fingering_sine_tone_generator_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int note;
      int run;
      int notes_hit;
      int goal;
      logic [4:0] btn;

      reset = 1'b1;

      for (int k = 0; k < LUT_SIZE; k++) sine_lut[k] = lut_value(k);
      for (int i = 0; i < vfst_pkg::CHART_LEN; i++) begin
         tone_step[i] = ((TONE_DHZ[i] << PHASE_BITS) + 5 * vfst_pkg::SAMPLE_RATE_HZ) /
                        (10 * vfst_pkg::SAMPLE_RATE_HZ);
      end

      // directed: chart corners, unplayable fingerings, sound off, button priority
      push_tick(3'b000, 5'b00000, 1'b0);
      push_tick(3'b000, 5'b00000, 1'b1);
      push_tick(3'b000, 5'b00000, 1'b1);
      push_tick(3'b000, 5'b00000, 1'b1);
      push_tick(3'b001, 5'b00001, 1'b1);
      push_tick(3'b111, 5'b11111, 1'b1);
      push_tick(3'b001, 5'b00000, 1'b1);
      push_tick(3'b111, 5'b00000, 1'b0);
      push_tick(3'b010, 5'b10000, 1'b1);
      push_tick(3'b010, 5'b10000, 1'b1);
      push_tick(3'b010, 5'b10000, 1'b1);
      push_tick(3'b000, 5'b11111, 1'b1);
      push_tick(3'b011, 5'b00010, 1'b1);
      push_tick(3'b110, 5'b00100, 1'b1);
      push_tick(3'b100, 5'b01000, 1'b1);
      push_tick(3'b000, 5'b01000, 1'b1);
      push_tick(3'b101, 5'b00000, 1'b0);
      push_tick(3'b101, 5'b00000, 1'b1);
      push_tick(3'b010, 5'b11110, 1'b1);
      push_tick(3'b100, 5'b10000, 1'b1);
      push_tick(3'b100, 5'b10000, 1'b0);

      // random: mostly held notes with random extra buttons, some noise
      goal = pending_ticks.size() + RANDOM_TICKS;
      while (pending_ticks.size() < goal) begin
         if ($urandom_range(0, 9) < 8) begin
            note = $urandom_range(0, vfst_pkg::CHART_LEN - 1);
            run  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
            for (int r = 0; r < run; r++) begin
               btn = 5'($urandom);
               if (TONE_OCTAVE[note] == 0) begin
                  btn = 5'd0;
               end else begin
                  btn = (btn & 5'(5'h1f << TONE_OCTAVE[note])) |
                        5'(1 << (TONE_OCTAVE[note] - 1));
               end
               push_tick(valves_for(TONE_CODE[note]), btn, $urandom_range(0, 15) != 0);
            end
         end else begin
            run = $urandom_range(1, 5);
            for (int r = 0; r < run; r++) begin
               push_tick(3'($urandom), 5'($urandom), 1'($urandom));
            end
         end
      end
      pending_ticks[DRAIN_AT].wait_drain = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_ticks.size() != 0 || req_chan.valid || tone_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      notes_hit = 0;
      foreach (note_sounded[i]) notes_hit += note_sounded[i];
      $display("covered %0d ticks in, %0d samples out, %0d silent ticks",
               req_taken, rsp_taken, silent_ticks);
      $display("%0d of %0d chart notes sounded, with back-pressure and a full drain",
               notes_hit, vfst_pkg::CHART_LEN);
      if (mismatch_count == 0) begin
         $display("valve_fingering_sine_tone_generator_top: match");
      end else begin
         $display("valve_fingering_sine_tone_generator_top: mismatch");
      end
      $finish;
   end

endmodule
